// ----- design/elsu_pkg.sv -----
// Embedding lookup / SGD update: shared constants, op codes and the
// command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package elsu_pkg;

  // Table geometry
  localparam int VOCAB = 1024;
  localparam int DIM   = 64;
  localparam int SEQ   = 256;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int TOK_W  = 10;
  localparam int POS_W  = 8;
  localparam int ELEM_W = 6;
  localparam int VAL_W  = 16;
  localparam int LR_W   = 16;

  // Derived widths
  localparam int CNT_W   = $clog2(SEQ + 1);
  localparam int HIST_AW = (SEQ > 1) ? $clog2(SEQ) : 1;
  localparam int WADDR_W = (VOCAB * DIM > 1) ? $clog2(VOCAB * DIM) : 1;
  localparam int PROD_W  = LR_W + VAL_W + 1;
  localparam int STEP_W  = VAL_W + 2;

  localparam logic [LR_W-1:0] LR_RESET = 16'd655;

  // Op codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_GRAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic record;    // place token in history, set output position
    logic issue;     // read one row element into the output register
    logic hist_rd;   // read history at the gradient position
    logic grad_rd;   // read the target weight, form rate * gradient
    logic grad_wr;   // write back the updated weight
    logic load_wr;   // write a loaded weight
  } elsu_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register free after this edge
    logic elem_last;  // element counter at DIM-1
    logic grad_ok;    // gradient position and element are in range
  } elsu_sts_t;

endpackage

// ----- design/elsu_in_if.sv -----
// Input channel: valid/ready handshake plus one item's fields.
// Depends on elsu_pkg.
`timescale 1ns / 1ps

interface elsu_in_if;
  logic                                valid;
  logic                                ready;
  logic [elsu_pkg::OP_W-1:0]           op;
  logic                                new_sequence;
  logic [elsu_pkg::TOK_W-1:0]          token;
  logic [elsu_pkg::POS_W-1:0]          position;
  logic [elsu_pkg::ELEM_W-1:0]         element;
  logic signed [elsu_pkg::VAL_W-1:0]   value;

  modport source (output valid, op, new_sequence, token, position, element, value,
                  input ready);
  modport sink   (input valid, op, new_sequence, token, position, element, value,
                  output ready);
endinterface

// ----- design/elsu_out_if.sv -----
// Result channel: valid/ready handshake plus one result beat's fields.
// Depends on elsu_pkg.
`timescale 1ns / 1ps

interface elsu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [elsu_pkg::VAL_W-1:0]   weight;
  logic [elsu_pkg::POS_W-1:0]          out_position;
  logic [elsu_pkg::ELEM_W-1:0]         out_element;
  logic                                last;

  modport source (output valid, weight, out_position, out_element, last, input ready);
  modport sink   (input valid, weight, out_position, out_element, last, output ready);
endinterface

// ----- design/elsu_ctrl.sv -----
// Controller FSM: sequences lookup, gradient and load items.
// Depends on elsu_pkg (command/status structs, op codes).
`timescale 1ns / 1ps

module elsu_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [elsu_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  input  elsu_pkg::elsu_sts_t       sts,
  output elsu_pkg::elsu_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REC  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_G1   = 3'd3;
  localparam logic [2:0] S_G2   = 3'd4;
  localparam logic [2:0] S_G3   = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_ready && in_valid;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.capture = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            elsu_pkg::OP_LOOKUP: state_nxt = S_REC;
            elsu_pkg::OP_GRAD:   state_nxt = S_G1;
            elsu_pkg::OP_LOAD:   state_nxt = S_LOAD;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_REC: begin
        cmd.record = 1'b1;
        state_nxt  = S_LOOK;
      end
      S_LOOK: begin
        cmd.issue = sts.slot_free;
        if (sts.slot_free && sts.elem_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_G1: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = sts.grad_ok ? S_G2 : S_IDLE;
      end
      S_G2: begin
        cmd.grad_rd = 1'b1;
        state_nxt   = S_G3;
      end
      S_G3: begin
        cmd.grad_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/elsu_dp.sv -----
// Datapath: weight table memory, token history memory, history count,
// learning-rate register, update arithmetic and the output register.
// Depends on elsu_pkg.
`timescale 1ns / 1ps

module elsu_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  elsu_pkg::elsu_cmd_t                cmd,
  output elsu_pkg::elsu_sts_t                sts,
  input  logic                               in_new_sequence,
  input  logic [elsu_pkg::TOK_W-1:0]         in_token,
  input  logic [elsu_pkg::POS_W-1:0]         in_position,
  input  logic [elsu_pkg::ELEM_W-1:0]        in_element,
  input  logic signed [elsu_pkg::VAL_W-1:0]  in_value,
  input  logic                               cfg_we,
  input  logic [elsu_pkg::LR_W-1:0]          cfg_wdata,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [elsu_pkg::VAL_W-1:0]  out_weight,
  output logic [elsu_pkg::POS_W-1:0]         out_position,
  output logic [elsu_pkg::ELEM_W-1:0]        out_element,
  output logic                               out_last
);

  localparam int TOKEN_W  = elsu_pkg::TOK_W;
  localparam int VW       = elsu_pkg::VAL_W;
  localparam int PW       = elsu_pkg::PROD_W;
  localparam int SW       = elsu_pkg::STEP_W;
  localparam int AW       = elsu_pkg::WADDR_W;
  localparam int HAW      = elsu_pkg::HIST_AW;
  localparam int CW       = elsu_pkg::CNT_W;
  localparam int EW       = elsu_pkg::ELEM_W;
  localparam int PSW      = elsu_pkg::POS_W;
  localparam int Depth    = elsu_pkg::VOCAB * elsu_pkg::DIM;

  // Latched item
  logic                 newseq_r;
  logic [TOKEN_W-1:0]   tok_r;
  logic [PSW-1:0]       gpos_r;
  logic [EW-1:0]        gelem_r;
  logic signed [VW-1:0] val_r;

  // Control / config state
  logic [elsu_pkg::LR_W-1:0] lr_r;
  logic [CW-1:0]             hist_cnt_r, hist_cnt_nxt;
  logic [PSW-1:0]            rec_pos_r;
  logic [EW-1:0]             elem_cnt_r;

  // Memories
  logic [TOKEN_W-1:0]   hist_mem [elsu_pkg::SEQ];
  logic [TOKEN_W-1:0]   hist_q;
  logic signed [VW-1:0] wt_mem [Depth];
  logic signed [VW-1:0] lk_q;
  logic signed [VW-1:0] gw_q;

  // Output register
  logic           out_valid_r;
  logic [PSW-1:0] out_pos_r;
  logic [EW-1:0]  out_elem_r;
  logic           out_last_r;
  logic           out_tokok_r;

  // Update pipeline
  logic signed [PW-1:0] prod_r;
  logic [AW-1:0]        gaddr_r;
  logic                 rowok_r;

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      newseq_r <= in_new_sequence;
      tok_r    <= in_token;
      gpos_r   <= in_position;
      gelem_r  <= in_element;
      val_r    <= in_value;
    end
  end

  // Learning rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= elsu_pkg::LR_RESET;
    end else if (cfg_we) begin
      lr_r <= cfg_wdata;
    end
  end

  // History record: new sequence restarts the count; full history not recorded
  logic [CW-1:0] cnt_base;
  logic          room;
  logic          hist_we;

  assign cnt_base = newseq_r ? '0 : hist_cnt_r;
  assign room     = (32'(cnt_base) < elsu_pkg::SEQ);
  assign hist_we  = cmd.record && room;

  always_comb begin
    hist_cnt_nxt = hist_cnt_r;
    if (cmd.record) begin
      hist_cnt_nxt = room ? cnt_base + CW'(1) : cnt_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_cnt_r <= '0;
    end else begin
      hist_cnt_r <= hist_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record) begin
      rec_pos_r <= room ? PSW'(cnt_base) : PSW'(elsu_pkg::SEQ - 1);
    end
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[HAW'(cnt_base)] <= tok_r;
    end
    if (cmd.hist_rd) begin
      hist_q <= hist_mem[HAW'(gpos_r)];
    end
  end

  // Element counter for lookup streaming
  always_ff @(posedge clk) begin
    if (cmd.record) begin
      elem_cnt_r <= '0;
    end else if (cmd.issue) begin
      elem_cnt_r <= elem_cnt_r + EW'(1);
    end
  end

  // Address and range checks
  logic          tok_ok;
  logic          load_ok;
  logic          row_ok;
  logic [AW-1:0] lk_addr;
  logic [AW-1:0] ld_addr;
  logic [AW-1:0] g_addr;

  assign tok_ok  = (32'(tok_r) < elsu_pkg::VOCAB);
  assign load_ok = tok_ok && (32'(gelem_r) < elsu_pkg::DIM);
  assign row_ok  = (32'(hist_q) < elsu_pkg::VOCAB);
  assign lk_addr = AW'(32'(tok_r) * elsu_pkg::DIM + 32'(elem_cnt_r));
  assign ld_addr = AW'(32'(tok_r) * elsu_pkg::DIM + 32'(gelem_r));
  assign g_addr  = AW'(32'(hist_q) * elsu_pkg::DIM + 32'(gelem_r));

  // Rate times gradient, registered
  logic signed [PW-1:0] lr_ext;
  logic signed [PW-1:0] val_ext;

  assign lr_ext  = $signed({{(PW - elsu_pkg::LR_W){1'b0}}, lr_r});
  assign val_ext = PW'(val_r);

  always_ff @(posedge clk) begin
    if (cmd.grad_rd) begin
      prod_r  <= lr_ext * val_ext;
      gaddr_r <= g_addr;
      rowok_r <= row_ok;
    end
  end

  // Round to nearest (ties up), subtract, saturate
  logic signed [PW-1:0] rnd;
  logic signed [SW-1:0] step;
  logic signed [SW-1:0] diff;
  logic signed [VW-1:0] new_w;

  assign rnd  = prod_r + PW'(32768);
  assign step = SW'(rnd >>> 16);
  assign diff = SW'(gw_q) - step;

  always_comb begin
    if (diff > SW'(32767)) begin
      new_w = {1'b0, {(VW-1){1'b1}}};
    end else if (diff < -SW'(32768)) begin
      new_w = {1'b1, {(VW-1){1'b0}}};
    end else begin
      new_w = diff[VW-1:0];
    end
  end

  // Weight memory: one write port, lookup and gradient read ports
  logic                 wt_we;
  logic [AW-1:0]        wt_waddr;
  logic signed [VW-1:0] wt_wdata;

  assign wt_we    = (cmd.load_wr && load_ok) || (cmd.grad_wr && rowok_r);
  assign wt_waddr = cmd.load_wr ? ld_addr : gaddr_r;
  assign wt_wdata = cmd.load_wr ? val_r : new_w;

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    if (cmd.issue) begin
      lk_q <= wt_mem[lk_addr];
    end
    if (cmd.grad_rd) begin
      gw_q <= wt_mem[g_addr];
    end
  end

  // Output register: lookup read data plus beat metadata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      out_pos_r   <= rec_pos_r;
      out_elem_r  <= elem_cnt_r;
      out_last_r  <= sts.elem_last;
      out_tokok_r <= tok_ok;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_weight   = out_tokok_r ? lk_q : '0;
  assign out_position = out_pos_r;
  assign out_element  = out_elem_r;
  assign out_last     = out_last_r;

  // Status
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.elem_last = (32'(elem_cnt_r) == elsu_pkg::DIM - 1);
  assign sts.grad_ok   = (32'(gpos_r) < 32'(hist_cnt_r))
                      && (32'(gpos_r) < elsu_pkg::SEQ)
                      && (32'(gelem_r) < elsu_pkg::DIM);

endmodule

// ----- design/embedding_lookup_sgd_update_top.sv -----
// Lookup: the token is recorded, then one result beat per cycle while out ready is high;
//   the next item is taken once the last element has been issued.
// Gradient item: history read, weight read + multiply, write-back (ignored: history read only).
// Load item: a single table write. The sequencer takes one item at a time.
// Reset (sync, active low) clears history count, FSM and output valid, and
// sets learning_rate to 655; table and history memories are not cleared.
`timescale 1ns / 1ps

module embedding_lookup_sgd_update_top (
  input  logic                          clk,
  input  logic                          rst_n,
  elsu_in_if.sink                       in_ch,
  elsu_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [elsu_pkg::LR_W-1:0]     cfg_wdata
);

  elsu_pkg::elsu_cmd_t cmd;
  elsu_pkg::elsu_sts_t sts;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  elsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories and arithmetic
  elsu_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_new_sequence (in_ch.new_sequence),
    .in_token        (in_ch.token),
    .in_position     (in_ch.position),
    .in_element      (in_ch.element),
    .in_value        (in_ch.value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_weight      (out_ch.weight),
    .out_position    (out_ch.out_position),
    .out_element     (out_ch.out_element),
    .out_last        (out_ch.last)
  );

`ifndef SYNTHESIS
  // Within a lookup, the beat after a non-last beat carries the next element
  a_elem_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=>
      (!out_ch.valid || out_ch.out_element == $past(out_ch.out_element) + 6'd1))
    else $error("lookup element sequence broken");

  // A table load write follows directly on an accepted load beat
  a_load_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> $past(in_ch.valid && in_ch.ready && in_ch.op == elsu_pkg::OP_LOAD))
    else $error("load write without load beat");

  // No input beat is taken while row elements are still being issued
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ch.ready)
    else $error("input accepted during lookup streaming");
`endif

endmodule
